// File: design/ckpq_pkg.sv
// Package for the composite key priority queue.
// Holds the record and result types, request codes, the controller states
// and the record ordering function. Depends on nothing.
package ckpq_pkg;

  localparam int TagW   = 32;
  localparam int RollW  = 16;
  localparam int MarksW = 10;
  localparam int FuncW  = 2;

  // Request codes; the unused code acts as a peek.
  localparam logic [FuncW-1:0] FUNC_PUSH = 2'd0;
  localparam logic [FuncW-1:0] FUNC_PEEK = 2'd1;
  localparam logic [FuncW-1:0] FUNC_POP  = 2'd2;

  typedef struct packed {
    logic [TagW-1:0]   tag;
    logic [RollW-1:0]  roll;
    logic [MarksW-1:0] marks;
  } rec_t;

  typedef struct packed {
    logic              is_empty;
    logic [TagW-1:0]   head_tag;
    logic [RollW-1:0]  head_roll;
    logic [MarksW-1:0] head_marks;
    logic              push_dropped;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP,
    S_UP_CMP,
    S_POP_RD,
    S_POP_LD,
    S_DN,
    S_DN_CMP,
    S_HEAD,
    S_RESULT
  } state_t;

  // Strict order: higher mark wins, then lower roll.
  function automatic logic rec_better(rec_t a, rec_t b);
    return (a.marks > b.marks) || ((a.marks == b.marks) && (a.roll < b.roll));
  endfunction

endpackage

// File: design/ckpq_ifs.sv
// Valid/ready channel interfaces for the request and response streams.
// Depends on ckpq_pkg for field widths.
interface ckpq_req_if;
  import ckpq_pkg::*;
  logic                valid;
  logic                ready;
  logic [FuncW-1:0]    func;
  logic [TagW-1:0]     entry_tag;
  logic [RollW-1:0]    entry_roll;
  logic [MarksW-1:0]   entry_marks;
  modport source (output valid, func, entry_tag, entry_roll, entry_marks, input ready);
  modport sink   (input valid, func, entry_tag, entry_roll, entry_marks, output ready);
endinterface

interface ckpq_rsp_if;
  import ckpq_pkg::*;
  logic                valid;
  logic                ready;
  logic                is_empty;
  logic [TagW-1:0]     head_tag;
  logic [RollW-1:0]    head_roll;
  logic [MarksW-1:0]   head_marks;
  logic                push_dropped;
  modport source (output valid, is_empty, head_tag, head_roll, head_marks, push_dropped,
                  input ready);
  modport sink   (input valid, is_empty, head_tag, head_roll, head_marks, push_dropped,
                  output ready);
endinterface

// File: design/ckpq_mem.sv
// Heap record storage: one write port, two registered read ports.
// Depends on ckpq_pkg for the record type.
module ckpq_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  ckpq_pkg::rec_t     wdata,
  input  logic [AW-1:0]      raddr_a,
  input  logic [AW-1:0]      raddr_b,
  output ckpq_pkg::rec_t     rdata_a,
  output ckpq_pkg::rec_t     rdata_b
);
  import ckpq_pkg::*;

  rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: design/ckpq_ctrl.sv
// Sift controller: takes requests, walks the heap through the record memory
// one level per state pair, then reads the head and presents the result.
// Depends on ckpq_pkg and the request interface.
module ckpq_ctrl #(
  parameter int CAPACITY = 64,
  parameter int AW       = 6,
  parameter int CW       = 7
) (
  input  logic               clk,
  input  logic               rst,
  ckpq_req_if.sink           req,
  output logic               mem_we,
  output logic [AW-1:0]      mem_waddr,
  output ckpq_pkg::rec_t     mem_wdata,
  output logic [AW-1:0]      mem_raddr_a,
  output logic [AW-1:0]      mem_raddr_b,
  input  ckpq_pkg::rec_t     mem_rdata_a,
  input  ckpq_pkg::rec_t     mem_rdata_b,
  output logic               res_valid,
  input  logic               res_ready,
  output ckpq_pkg::result_t  res_data
);
  import ckpq_pkg::*;

  localparam int WW = AW + 2;

  state_t          state, state_next;
  rec_t            cur, cur_next;
  logic [AW-1:0]   idx, idx_next;
  logic [CW-1:0]   count, count_next;
  logic            dropped, dropped_next;

  logic [WW-1:0]   left_w, right_w, count_w;
  logic [AW-1:0]   left_a, right_a, parent_a;
  logic            left_ok, right_ok, up_swap, dn_swap, pick_right;
  logic            full, accept;
  rec_t            child;

  assign count_w  = WW'(count);
  assign left_w   = WW'({idx, 1'b1});
  assign right_w  = left_w + WW'(1);
  assign left_a   = AW'(left_w);
  assign right_a  = AW'(right_w);
  assign parent_a = AW'((idx - AW'(1)) >> 1);
  assign left_ok  = left_w < count_w;
  assign right_ok = right_w < count_w;
  assign full     = count >= CW'(CAPACITY);
  assign accept   = req.valid && req.ready;

  assign up_swap    = rec_better(cur, mem_rdata_a);
  assign pick_right = right_ok && rec_better(mem_rdata_b, mem_rdata_a);
  assign child      = pick_right ? mem_rdata_b : mem_rdata_a;
  assign dn_swap    = rec_better(child, cur);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.func == FUNC_PUSH && !full) begin
            state_next = S_UP;
          end else if (req.func == FUNC_POP && count != '0) begin
            state_next = S_POP_RD;
          end else begin
            state_next = S_HEAD;
          end
        end
      end
      S_UP:     state_next = (idx == '0) ? S_HEAD : S_UP_CMP;
      S_UP_CMP: state_next = up_swap ? S_UP : S_HEAD;
      S_POP_RD: state_next = S_POP_LD;
      S_POP_LD: state_next = S_DN;
      S_DN:     state_next = left_ok ? S_DN_CMP : S_HEAD;
      S_DN_CMP: state_next = dn_swap ? S_DN : S_HEAD;
      S_HEAD:   state_next = S_RESULT;
      S_RESULT: state_next = res_ready ? S_IDLE : S_RESULT;
      default:  state_next = S_IDLE;
    endcase
  end

  // Outputs and datapath updates.
  always_comb begin
    req.ready    = 1'b0;
    res_valid    = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = idx;
    mem_wdata    = cur;
    mem_raddr_a  = '0;
    mem_raddr_b  = right_a;
    cur_next     = cur;
    idx_next     = idx;
    count_next   = count;
    dropped_next = dropped;
    res_data     = '0;
    case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        if (accept) begin
          dropped_next = 1'b0;
          if (req.func == FUNC_PUSH) begin
            if (full) begin
              dropped_next = 1'b1;
            end else begin
              cur_next   = '{tag: req.entry_tag, roll: req.entry_roll,
                             marks: req.entry_marks};
              idx_next   = AW'(count);
              count_next = count + CW'(1);
            end
          end else if (req.func == FUNC_POP && count != '0) begin
            count_next = count - CW'(1);
          end
        end
      end
      S_UP: begin
        mem_raddr_a = parent_a;
        if (idx == '0) begin
          mem_we = 1'b1;
        end
      end
      S_UP_CMP: begin
        mem_we = 1'b1;
        if (up_swap) begin
          mem_wdata = mem_rdata_a;
          idx_next  = parent_a;
        end
      end
      S_POP_RD: begin
        mem_raddr_a = AW'(count);
      end
      S_POP_LD: begin
        cur_next = mem_rdata_a;
        idx_next = '0;
      end
      S_DN: begin
        mem_raddr_a = left_a;
        mem_raddr_b = right_a;
        if (!left_ok) begin
          mem_we = 1'b1;
        end
      end
      S_DN_CMP: begin
        mem_we = 1'b1;
        if (dn_swap) begin
          mem_wdata = child;
          idx_next  = pick_right ? right_a : left_a;
        end
      end
      S_HEAD: begin
        mem_raddr_a = '0;
      end
      S_RESULT: begin
        // Keep slot 0 on the read port so the data holds while stalled.
        mem_raddr_a           = '0;
        res_valid             = 1'b1;
        res_data.push_dropped = dropped;
        if (count == '0) begin
          res_data.is_empty = 1'b1;
        end else begin
          res_data.head_tag   = mem_rdata_a.tag;
          res_data.head_roll  = mem_rdata_a.roll;
          res_data.head_marks = mem_rdata_a.marks;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      dropped <= dropped_next;
    end
    cur <= cur_next;
    idx <= idx_next;
  end

endmodule

// File: design/composite_key_priority_queue_unit.sv
// Composite key priority queue: a bounded binary heap of records (tag, roll, mark),
// best record first by highest mark, then lowest roll. Each request is a push,
// a peek or a pop and returns one response with the new head (or is_empty) and
// push_dropped for a push that found the queue full. Requests are handled one
// at a time. The heap lives in a record memory with one write port and two
// registered read ports; a push sifts up one level per read and compare-write
// state pair, a pop loads the last record and sifts down the same way, then
// slot 0 is read; a peek goes straight to the read of slot 0. A finished
// response waits in an output register so the next request can be accepted
// while it is held. The memory needs no clearing after reset: only slots below
// the record count are used.
// Depends on ckpq_pkg, ckpq_ifs, ckpq_mem and ckpq_ctrl.
module composite_key_priority_queue_unit #(
  parameter int CAPACITY = 64
) (
  input  logic      clk,
  input  logic      rst,
  ckpq_req_if.sink  req,
  ckpq_rsp_if.source rsp
);
  import ckpq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr_a, mem_raddr_b;
  rec_t          mem_wdata, mem_rdata_a, mem_rdata_b;

  logic          res_valid, res_ready;
  result_t       res_data;

  logic          out_valid;
  result_t       out_data;

  ckpq_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rdata_a (mem_rdata_a),
    .rdata_b (mem_rdata_b)
  );

  ckpq_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr_a (mem_raddr_a),
    .mem_raddr_b (mem_raddr_b),
    .mem_rdata_a (mem_rdata_a),
    .mem_rdata_b (mem_rdata_b),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_data    (res_data)
  );

  // Output register: load a finished response whenever the slot is empty or
  // being drained; hold it otherwise.
  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
    if (res_ready && res_valid) begin
      out_data <= res_data;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.is_empty     = out_data.is_empty;
  assign rsp.head_tag     = out_data.head_tag;
  assign rsp.head_roll    = out_data.head_roll;
  assign rsp.head_marks   = out_data.head_marks;
  assign rsp.push_dropped = out_data.push_dropped;

  // An empty queue reports all-zero head fields.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.is_empty |->
      out_data.head_tag == '0 && out_data.head_roll == '0 && out_data.head_marks == '0)
    else $error("empty response carries a nonzero head");

  // A dropped push means the queue is full, so it cannot be empty.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.push_dropped |-> !out_data.is_empty)
    else $error("dropped push reported with an empty queue");

  // The controller never takes a new request while it presents a response.
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !req.ready)
    else $error("request accepted while a response is pending");

  // A response held back by a stalled output keeps the controller waiting.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("pending response changed or vanished under stall");

endmodule

// File: tb/tb_top.sv
// Self-checking bench for composite_key_priority_queue_unit: a directed opening,
// then phased random request traffic, with every response checked against a heap predictor.
// Depends on ckpq_pkg, ckpq_ifs and the queue unit itself.
module tb_top;
  import ckpq_pkg::*;

  localparam int QueueDepth   = 64;
  localparam int PhaseCount   = 8;
  localparam int FillItems    = 90;   // push-heavy part of each phase
  localparam int DrainItems   = 60;   // pop-heavy part of each phase
  localparam int HoldOffLen   = 300;  // long receiver stall, in cycles
  localparam int SettleCycles = 40;   // well past the longest push or pop latency
  localparam int QuietLimit   = 2000; // cycles without any handshake before giving up

  // The spare request code behaves as a peek.
  localparam logic [FuncW-1:0] FUNC_SPARE = 2'd3;

  // Heap predictor plus the list of responses still owed by the block.
  class heap_scoreboard;
    rec_t        slots[QueueDepth];
    int unsigned held;
    result_t     owed[$];
    int          errors;

    function new();
      held   = 0;
      errors = 0;
    endfunction

    // Higher mark first; lower roll breaks a tie on mark.
    function bit outranks(rec_t a, rec_t b);
      return {a.marks, ~a.roll} > {b.marks, ~b.roll};
    endfunction

    function void swap(int unsigned i, int unsigned j);
      rec_t t;
      t        = slots[i];
      slots[i] = slots[j];
      slots[j] = t;
    endfunction

    function void sift_in(rec_t r);
      int unsigned i;
      int unsigned p;
      i = held;
      slots[i] = r;
      held++;
      while (i > 0) begin
        p = (i - 1) / 2;
        if (!outranks(slots[i], slots[p])) break;
        swap(i, p);
        i = p;
      end
    endfunction

    // Move the last record to the top and sift it down; left child wins ties.
    function void remove_head();
      int unsigned i;
      int unsigned c;
      i = 0;
      held--;
      slots[0] = slots[held];
      while (2 * i + 1 < held) begin
        c = 2 * i + 1;
        if (c + 1 < held && outranks(slots[c + 1], slots[c])) c = c + 1;
        if (!outranks(slots[c], slots[i])) break;
        swap(i, c);
        i = c;
      end
    endfunction

    // Apply one accepted request and queue the response it must produce.
    function void note_request(logic [FuncW-1:0] op, rec_t r);
      result_t want;
      want = '0;
      if (op == FUNC_PUSH) begin
        if (held >= QueueDepth) want.push_dropped = 1'b1;
        else sift_in(r);
      end else if (op == FUNC_POP) begin
        if (held > 0) remove_head();
      end
      if (held == 0) begin
        want.is_empty = 1'b1;
      end else begin
        want.head_tag   = slots[0].tag;
        want.head_roll  = slots[0].roll;
        want.head_marks = slots[0].marks;
      end
      owed.push_back(want);
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned seen);
      if (want != seen) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, seen);
        errors++;
      end
    endfunction

    function void check_response(result_t got);
      result_t want;
      if (owed.size() == 0) begin
        $display("%0t: unexpected response, expected none, got %0h", $time, got);
        errors++;
        return;
      end
      want = owed.pop_front();
      compare_field("is_empty",     want.is_empty,     got.is_empty);
      compare_field("head_tag",     want.head_tag,     got.head_tag);
      compare_field("head_roll",    want.head_roll,    got.head_roll);
      compare_field("head_marks",   want.head_marks,   got.head_marks);
      compare_field("push_dropped", want.push_dropped, got.push_dropped);
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  ckpq_req_if req_ch();
  ckpq_rsp_if rsp_ch();

  composite_key_priority_queue_unit #(.CAPACITY(QueueDepth)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  heap_scoreboard sb;

  // Idle knobs, set per phase by the stimulus process.
  int send_gap_pct  = 0;
  int stall_pct     = 0;
  // Hold-off handshake: the stimulus bumps the ask count, the receiver counts it out.
  int holdoff_asked = 0;
  int holdoff_seen  = 0;
  int holdoff_left  = 0;
  result_t seen_rsp;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Receiver: drive ready at the falling edge. A pending hold-off wins over the
  // random stall so that the block backs up all the way into its request port.
  always @(negedge clk) begin
    if (holdoff_left > 0) begin
      holdoff_left  = holdoff_left - 1;
      rsp_ch.ready = 1'b0;
    end else if (holdoff_seen != holdoff_asked) begin
      holdoff_seen  = holdoff_asked;
      holdoff_left  = HoldOffLen - 1;
      rsp_ch.ready = 1'b0;
    end else begin
      rsp_ch.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  // Check every response taken at a rising edge.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      seen_rsp.is_empty     = rsp_ch.is_empty;
      seen_rsp.head_tag     = rsp_ch.head_tag;
      seen_rsp.head_roll    = rsp_ch.head_roll;
      seen_rsp.head_marks   = rsp_ch.head_marks;
      seen_rsp.push_dropped = rsp_ch.push_dropped;
      sb.check_response(seen_rsp);
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("composite_key_priority_queue_unit regression: fail");
    $finish;
  end

  function automatic rec_t make_rec(logic [TagW-1:0] tag, logic [RollW-1:0] roll,
                                    logic [MarksW-1:0] marks);
    rec_t r;
    r.tag   = tag;
    r.roll  = roll;
    r.marks = marks;
    return r;
  endfunction

  // Half the records come from a tiny key space so that marks and rolls tie often.
  function automatic rec_t random_rec();
    rec_t r;
    r.tag = $urandom;
    if ($urandom_range(1) == 1) begin
      r.roll  = RollW'($urandom_range(3));
      r.marks = MarksW'($urandom_range(3));
    end else begin
      r.roll  = RollW'($urandom);
      r.marks = MarksW'($urandom);
    end
    return r;
  endfunction

  function automatic logic [FuncW-1:0] random_func(int push_pct);
    int pick;
    pick = $urandom_range(99);
    if (pick < push_pct) return FUNC_PUSH;
    pick = $urandom_range(9);
    if (pick < 7) return FUNC_POP;
    if (pick < 9) return FUNC_PEEK;
    return FUNC_SPARE;
  endfunction

  // Offer one request from a falling edge and hold it until taken. Valid stays
  // high into the next request unless the random gap drops it.
  task automatic offer(input logic [FuncW-1:0] op, input rec_t r);
    req_ch.valid       = 1'b1;
    req_ch.func        = op;
    req_ch.entry_tag   = r.tag;
    req_ch.entry_roll  = r.roll;
    req_ch.entry_marks = r.marks;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(op, r);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
  endtask

  // Drop valid and wait out every owed response.
  task automatic drain();
    req_ch.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  initial begin
    int phase;
    int n;
    int push_pct;

    sb                 = new();
    rst                = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.func        = FUNC_PEEK;
    req_ch.entry_tag   = '0;
    req_ch.entry_roll  = '0;
    req_ch.entry_marks = '0;
    rsp_ch.ready       = 1'b0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // Directed opening: empty queue, key extremes, ties on mark and on both keys.
    offer(FUNC_PEEK,  make_rec(32'h0, 16'h0, 10'h0));
    offer(FUNC_POP,   make_rec(32'hffff_ffff, 16'hffff, 10'h3ff));  // pop on empty
    offer(FUNC_SPARE, make_rec(32'h1234_5678, 16'h1, 10'h1));       // spare code on empty
    offer(FUNC_PUSH,  make_rec(32'h0, 16'h0, 10'h0));
    offer(FUNC_PUSH,  make_rec(32'hffff_ffff, 16'hffff, 10'h3ff));
    offer(FUNC_PUSH,  make_rec(32'h5555_5555, 16'h0, 10'h3ff));     // same mark, lower roll
    offer(FUNC_PUSH,  make_rec(32'haaaa_aaaa, 16'h0, 10'h3ff));     // full tie, keeps head
    offer(FUNC_PUSH,  make_rec(32'h0f0f_0f0f, 16'h8000, 10'h200));
    offer(FUNC_PEEK,  make_rec(32'h0, 16'h0, 10'h0));
    offer(FUNC_SPARE, make_rec(32'h0, 16'h0, 10'h0));
    repeat (5) offer(FUNC_POP, make_rec(32'h0, 16'h0, 10'h0));
    offer(FUNC_POP,   make_rec(32'h0, 16'h0, 10'h0));               // pop on empty again
    offer(FUNC_PUSH,  make_rec(32'h1111_1111, 16'h7, 10'h5));
    offer(FUNC_PUSH,  make_rec(32'h2222_2222, 16'h7, 10'h5));
    offer(FUNC_PUSH,  make_rec(32'h3333_3333, 16'h6, 10'h5));
    offer(FUNC_PUSH,  make_rec(32'h4444_4444, 16'h7, 10'h5));
    repeat (4) offer(FUNC_POP, make_rec(32'h0, 16'h0, 10'h0));
    drain();

    // Random phases: each has a push-heavy fill part (drops when full), then a
    // pop-heavy drain part. The idle pattern rotates through the four modes.
    for (phase = 0; phase < PhaseCount; phase++) begin
      case (phase % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 63; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 63; end
        default: begin send_gap_pct = 6; stall_pct = 6; end
      endcase
      for (n = 0; n < FillItems + DrainItems; n++) begin
        push_pct = (n < FillItems) ? 75 : 10;
        // Starve the response side once while requests keep coming.
        if (phase == 2 && n == 40) holdoff_asked = holdoff_asked + 1;
        offer(random_func(push_pct), random_rec());
      end
      // Pause the sender until the block has answered everything.
      drain();
    end

    repeat (SettleCycles) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("composite_key_priority_queue_unit regression: pass");
    end else begin
      $display("composite_key_priority_queue_unit regression: fail");
    end
    $finish;
  end

endmodule
